### rtl/cbt_pkg.sv
// Shared constants, types and state encoding for the cubic Bezier tessellator.
// Used by every module of the block; depends on nothing.

package cbt_pkg;

   localparam int COORD_W         = 16;
   localparam int RES_W           = 6;
   localparam int MAX_RES_DEFAULT = 63;
   localparam logic [RES_W-1:0] RES_RESET = 6'd16;

   // t and u are Q0.16 held in 17 bits so that t = 1.0 is representable.
   localparam int T_W = 17;
   localparam logic [T_W-1:0] T_ONE = 17'h10000;

   localparam int SQ_W      = 2 * (T_W - 1) + 1;
   localparam int WGT_FRAC  = 3 * (T_W - 1);
   localparam int WGT_W     = WGT_FRAC + 1;
   localparam int WGT_SPLIT = 24;
   localparam int ACC_W     = WGT_FRAC + COORD_W;

   localparam int DIV_STEPS = T_W;

   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;
   localparam int CSR_IW  = CSR_AW - 2;
   localparam logic [CSR_IW-1:0] REG_RESOLUTION = 1'b0;

   localparam logic [COORD_W-1:0] COORD_BIAS = 16'h8000;

   typedef logic [3:0][COORD_W-1:0] ctrl_pts_type;
   typedef logic [3:0][WGT_W-1:0]   weights_type;

   typedef struct packed {
      logic        valid;
      logic        last;
      weights_type w;
   } wgt_beat_type;

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } seq_state_type;

endpackage

### rtl/cbt_divider.sv
// Bit-serial restoring divider that forms floor(1.0 / n) in Q0.16 and twice the remainder.
// Depends on cbt_pkg.

module cbt_divider import cbt_pkg::*; #(
   parameter int NW = 6
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [NW-1:0]  divisor,
   output logic           busy,
   output logic [T_W-1:0] quotient,
   output logic [NW:0]    rem_twice
);

   localparam int CNT_W = $clog2(DIV_STEPS);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NW-1:0]    rem_ff, rem_in;
   logic [T_W-1:0]   quo_ff, quo_in;
   logic [NW:0]      trial;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      trial   = {rem_ff, quo_ff[T_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = T_ONE;
      end else if (busy_ff) begin
         // The dividend shifts out of the top of the quotient register, one bit a cycle.
         if (trial >= {1'b0, divisor}) begin
            rem_in = NW'(trial - {1'b0, divisor});
            quo_in = {quo_ff[T_W-2:0], 1'b1};
         end else begin
            rem_in = trial[NW-1:0];
            quo_in = {quo_ff[T_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
         rem_ff  <= '0;
         quo_ff  <= T_ONE;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
      end
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign rem_twice = {rem_ff, 1'b0};

endmodule

### rtl/cbt_weights.sv
// Three-stage pipeline that turns a parameter t into the four Bernstein weights in Q0.48.
// Depends on cbt_pkg.

module cbt_weights import cbt_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  logic           in_valid,
   input  logic           in_last,
   input  logic [T_W-1:0] in_t,
   output wgt_beat_type   out_beat,
   output logic           busy
);

   logic               a_valid_ff, a_last_ff;
   logic [T_W-1:0]     a_t_ff, a_u_ff;
   logic [SQ_W-1:0]    a_uu_ff, a_tt_ff;
   logic [T_W-1:0]     u_in;
   logic [2*T_W-1:0]   uu_prod, tt_prod;

   logic               b_valid_ff, b_last_ff;
   logic [WGT_W-1:0]   b_w0_ff, b_m1_ff, b_m2_ff, b_w3_ff;
   logic [SQ_W+T_W-1:0] p0, p1, p2, p3;

   logic               c_valid_ff, c_last_ff;
   weights_type        c_w_ff;
   logic [WGT_W:0]     m1_x3, m2_x3;

   assign u_in    = T_ONE - in_t;
   assign uu_prod = u_in * u_in;
   assign tt_prod = in_t * in_t;

   assign p0 = a_uu_ff * a_u_ff;
   assign p1 = a_uu_ff * a_t_ff;
   assign p2 = a_tt_ff * a_u_ff;
   assign p3 = a_tt_ff * a_t_ff;

   assign m1_x3 = {b_m1_ff, 1'b0} + {1'b0, b_m1_ff};
   assign m2_x3 = {b_m2_ff, 1'b0} + {1'b0, b_m2_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_last_ff <= in_last;
         a_t_ff    <= in_t;
         a_u_ff    <= u_in;
         a_uu_ff   <= uu_prod[SQ_W-1:0];
         a_tt_ff   <= tt_prod[SQ_W-1:0];

         b_last_ff <= a_last_ff;
         b_w0_ff   <= p0[WGT_W-1:0];
         b_m1_ff   <= p1[WGT_W-1:0];
         b_m2_ff   <= p2[WGT_W-1:0];
         b_w3_ff   <= p3[WGT_W-1:0];

         c_last_ff <= b_last_ff;
         c_w_ff[0] <= b_w0_ff;
         c_w_ff[1] <= m1_x3[WGT_W-1:0];
         c_w_ff[2] <= m2_x3[WGT_W-1:0];
         c_w_ff[3] <= b_w3_ff;
      end
   end

   assign out_beat = {c_valid_ff, c_last_ff, c_w_ff};
   assign busy     = a_valid_ff | b_valid_ff | c_valid_ff;

endmodule

### rtl/cbt_lane.sv
// One coordinate lane: weighted sum of four biased control coordinates, rounded to Q8.8.
// Depends on cbt_pkg.

module cbt_lane import cbt_pkg::*; (
   input  logic               clock,
   input  logic               advance,
   input  ctrl_pts_type       coords,
   input  weights_type        wgt,
   output logic [COORD_W-1:0] sample
);

   localparam int HI_W     = COORD_W + WGT_W - WGT_SPLIT;
   localparam int LO_W     = COORD_W + WGT_SPLIT;
   localparam int SUM_HI_W = ACC_W - WGT_SPLIT;
   localparam int SUM_LO_W = LO_W + 2;
   localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (WGT_FRAC - 1);

   logic [3:0][HI_W-1:0] hi_ff;
   logic [3:0][LO_W-1:0] lo_ff;
   logic [SUM_HI_W-1:0]  sum_hi_ff, sum_hi_in;
   logic [SUM_LO_W-1:0]  sum_lo_ff, sum_lo_in;
   logic [ACC_W-1:0]     acc;

   // Each weight is split so that no product is wider than 16 by 25 bits.
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 4; i++) begin
            hi_ff[i] <= coords[i] * wgt[i][WGT_W-1:WGT_SPLIT];
            lo_ff[i] <= coords[i] * wgt[i][WGT_SPLIT-1:0];
         end
         sum_hi_ff <= sum_hi_in;
         sum_lo_ff <= sum_lo_in;
      end
   end

   // The true sum stays below 2^64, so the high part may be kept modulo 2^40.
   always_comb begin
      sum_hi_in = '0;
      sum_lo_in = '0;
      for (int i = 0; i < 4; i++) begin
         sum_hi_in = sum_hi_in + SUM_HI_W'(hi_ff[i]);
         sum_lo_in = sum_lo_in + SUM_LO_W'(lo_ff[i]);
      end
   end

   assign acc    = {sum_hi_ff, WGT_SPLIT'(0)} + ACC_W'(sum_lo_ff) + ROUND_HALF;
   assign sample = acc[ACC_W-1:WGT_FRAC] ^ COORD_BIAS;

endmodule

### rtl/cubic_bezier_tessellator_core.sv
// Cubic Bezier tessellator. Control points arrive one beat each; segments share end points
// (0-3, 3-6, ...). The beat that completes a segment starts a run of n+1 sample beats at
// t = k/n, k = 0..n, with n the resolution register (0 reads as 1, larger values clamp to
// MAX_RESOLUTION); the t = 1 beat carries last_of_run. A beat that does not complete a
// segment is taken while the sequencer is idle and the step divider is not busy. A completing beat
// is taken once the first four stages of the sample pipeline are empty and then holds the input
// while the sequencer issues one t per cycle, none while the output stalls; each sample then passes
// s1, the weight stages a, b and c, the lane product and sum registers and the output register, and
// samples leave one per cycle while rsp_ready is high. The step divider that derives the
// per-sample t increment runs after reset and after each write to the resolution register, and
// no beat is accepted meanwhile. Three identical lanes evaluate x, y and z side by side from shared
// weights; the output register merges them into one beat.
// Depends on cbt_pkg, cbt_divider, cbt_weights and cbt_lane.

module cubic_bezier_tessellator_core import cbt_pkg::*; #(
   parameter int MAX_RESOLUTION = MAX_RES_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_start_curve,
   input  logic signed [COORD_W-1:0] req_point_x,
   input  logic signed [COORD_W-1:0] req_point_y,
   input  logic signed [COORD_W-1:0] req_point_z,

   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [COORD_W-1:0] rsp_curve_x,
   output logic signed [COORD_W-1:0] rsp_curve_y,
   output logic signed [COORD_W-1:0] rsp_curve_z,
   output logic                      rsp_last_of_run,

   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_AW-1:0]         csr_paddr,
   input  logic [CSR_DW-1:0]         csr_pwdata,
   output logic [CSR_DW-1:0]         csr_prdata,
   output logic                      csr_pready
);

   localparam int NW = $clog2(MAX_RESOLUTION + 1);

   // Configuration
   logic              csr_wr, csr_hit;
   logic [RES_W-1:0]  res_ff, res_in;
   logic [NW-1:0]     n_eff;
   logic [NW:0]       two_n;

   // Step divider
   logic              div_busy;
   logic [T_W-1:0]    t_step;
   logic [NW:0]       r_step;

   // Point store and sequencer
   logic [3*COORD_W-1:0] point_word;
   logic [3*COORD_W-1:0] held_ff [3];
   logic [1:0]        held_idx;
   logic [2:0][3:0][COORD_W-1:0] seg_ff;
   logic [1:0]        fill_ff, fill_in;
   logic              started_ff, started_in;
   logic              accept, restart, completes, front_busy, issue, advance;
   seq_state_type     state_ff, state_in;
   logic [T_W-1:0]    t_acc_ff, t_acc_in;
   logic [NW:0]       r_acc_ff, r_acc_in;
   logic [NW+1:0]     r_sum;
   logic              carry;
   logic [NW-1:0]     k_ff, k_in;

   // Sample pipeline
   logic              s1_valid_ff, s1_last_ff;
   logic [T_W-1:0]    s1_t_ff;
   wgt_beat_type      wgt_beat;
   logic              wgt_busy;
   logic              l1_valid_ff, l1_last_ff, l2_valid_ff, l2_last_ff;
   logic [2:0][COORD_W-1:0] lane_sample;
   logic              rsp_valid_ff, rsp_last_ff;
   logic [2:0][COORD_W-1:0] rsp_data_ff;

   // ---------------------------------------------------------------- configuration
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_hit    = csr_paddr[CSR_AW-1:2] == REG_RESOLUTION;
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? CSR_DW'(res_ff) : '0;

   assign res_in = (csr_wr && csr_hit) ? csr_pwdata[RES_W-1:0] : res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff <= RES_RESET;
      end else begin
         res_ff <= res_in;
      end
   end

   always_comb begin
      if (res_ff == '0) begin
         n_eff = NW'(1);
      end else if (res_ff > RES_W'(MAX_RESOLUTION)) begin
         n_eff = NW'(MAX_RESOLUTION);
      end else begin
         n_eff = res_ff[NW-1:0];
      end
   end

   assign two_n = {n_eff, 1'b0};

   cbt_divider #(.NW(NW)) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (csr_wr && csr_hit),
      .divisor   (n_eff),
      .busy      (div_busy),
      .quotient  (t_step),
      .rem_twice (r_step)
   );

   // ---------------------------------------------------------------- point store
   assign point_word = {req_point_z, req_point_y, req_point_x};
   assign restart    = req_start_curve || !started_ff;
   assign completes  = !restart && (fill_ff == 2'd3);
   assign front_busy = s1_valid_ff | wgt_busy;
   assign advance    = !rsp_valid_ff || rsp_ready;
   assign accept     = req_valid && req_ready;
   assign held_idx   = (restart || completes) ? 2'd0 : fill_ff;

   always_comb begin
      fill_in    = fill_ff;
      started_in = started_ff;
      if (accept) begin
         if (restart || completes) begin
            fill_in    = 2'd1;
            started_in = 1'b1;
         end else begin
            fill_in = fill_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff[held_idx] <= point_word;
      end
      // A new segment is taken only when no earlier sample still needs the old one.
      if (accept && completes) begin
         for (int c = 0; c < 3; c++) begin
            seg_ff[c][0] <= held_ff[0][COORD_W*c +: COORD_W] ^ COORD_BIAS;
            seg_ff[c][1] <= held_ff[1][COORD_W*c +: COORD_W] ^ COORD_BIAS;
            seg_ff[c][2] <= held_ff[2][COORD_W*c +: COORD_W] ^ COORD_BIAS;
            seg_ff[c][3] <= point_word[COORD_W*c +: COORD_W] ^ COORD_BIAS;
         end
      end
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && completes) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (advance && k_ff == n_eff) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      issue     = 1'b0;
      case (state_ff)
         ST_IDLE: req_ready = !div_busy && !(completes && front_busy);
         ST_EMIT: issue     = advance;
         default: ;
      endcase
   end

   // t_k = floor((k*2^17 + n) / 2n) is kept as quotient and remainder, stepped by 2^17.
   assign r_sum = {1'b0, r_acc_ff} + {1'b0, r_step};
   assign carry = r_sum >= {1'b0, two_n};

   always_comb begin
      t_acc_in = t_acc_ff;
      r_acc_in = r_acc_ff;
      k_in     = k_ff;
      if (accept && completes) begin
         t_acc_in = '0;
         r_acc_in = {1'b0, n_eff};
         k_in     = '0;
      end else if (issue) begin
         t_acc_in = t_acc_ff + t_step + T_W'(carry);
         r_acc_in = carry ? (NW+1)'(r_sum - {1'b0, two_n}) : r_sum[NW:0];
         k_in     = k_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         fill_ff     <= '0;
         started_ff  <= 1'b0;
         t_acc_ff    <= '0;
         r_acc_ff    <= '0;
         k_ff        <= '0;
         s1_valid_ff <= 1'b0;
         l1_valid_ff <= 1'b0;
         l2_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         started_ff  <= started_in;
         t_acc_ff    <= t_acc_in;
         r_acc_ff    <= r_acc_in;
         k_ff        <= k_in;
         if (advance) begin
            s1_valid_ff  <= issue;
            l1_valid_ff  <= wgt_beat.valid;
            l2_valid_ff  <= l1_valid_ff;
            rsp_valid_ff <= l2_valid_ff;
         end
      end
   end

   // ---------------------------------------------------------------- sample pipeline
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_t_ff     <= t_acc_ff;
         s1_last_ff  <= k_ff == n_eff;
         l1_last_ff  <= wgt_beat.last;
         l2_last_ff  <= l1_last_ff;
         rsp_last_ff <= l2_last_ff;
         rsp_data_ff <= lane_sample;
      end
   end

   cbt_weights u_weights (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (s1_valid_ff),
      .in_last  (s1_last_ff),
      .in_t     (s1_t_ff),
      .out_beat (wgt_beat),
      .busy     (wgt_busy)
   );

   for (genvar c = 0; c < 3; c++) begin : g_lane
      cbt_lane u_lane (
         .clock   (clock),
         .advance (advance),
         .coords  (seg_ff[c]),
         .wgt     (wgt_beat.w),
         .sample  (lane_sample[c])
      );
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_last_of_run = rsp_last_ff;
   assign rsp_curve_x     = rsp_data_ff[0];
   assign rsp_curve_y     = rsp_data_ff[1];
   assign rsp_curve_z     = rsp_data_ff[2];

   // ---------------------------------------------------------------- assertions
   a_last_is_one: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_last_ff |-> s1_t_ff == T_ONE)
      else $error("last sample of a run does not sit at t = 1");

   a_rem_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> r_acc_ff < two_n)
      else $error("t remainder out of range");

   a_fill_consistent: assert property (@(posedge clock) disable iff (reset)
      started_ff == (fill_ff != 2'd0))
      else $error("fill count disagrees with curve state");

   a_run_start: assert property (@(posedge clock) disable iff (reset)
      accept && completes |=> state_ff == ST_EMIT && k_ff == '0 && t_acc_ff == '0)
      else $error("segment run did not start at t = 0");

endmodule
